FILE: src/gsb_pkg.sv
// Shared types and GF(2^8) helper functions for the AES S-box unit.
package gsb_pkg;

	// Field reduction for x^8 + x^4 + x^3 + x + 1
	localparam logic [7:0] GF_REDUCE        = 8'h1b;
	localparam logic [7:0] AFFINE_FWD_CONST = 8'h63;
	localparam logic [7:0] AFFINE_INV_CONST = 8'h05;
	localparam logic [7:0] GF_ONE           = 8'h01;

	// Operation codes carried on the mode field
	typedef enum logic [1:0] {
		MODE_MUL  = 2'd0,
		MODE_INV  = 2'd1,
		MODE_SBOX = 2'd2,
		MODE_ISBOX = 2'd3
	} gsb_mode_t;

	// Per-stage control that travels with the data
	typedef struct packed {
		logic valid;
		logic mul;
		logic fwd;
	} gsb_ctl_t;

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned n);
		logic [15:0] dbl;
		dbl = {v, v} << (n % 8);
		return dbl[15:8];
	endfunction

	// Shift-and-add multiply with reduction at each step
	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			acc = acc[7] ? ((acc << 1) ^ GF_REDUCE) : (acc << 1);
			if (x[i]) begin
				acc = acc ^ y;
			end
		end
		return acc;
	endfunction

	// Squaring is linear over GF(2); synthesis reduces this to XORs
	function automatic logic [7:0] gf_sq(input logic [7:0] x);
		return gf_mul(x, x);
	endfunction

	function automatic logic [7:0] affine_fwd(input logic [7:0] x);
		return x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4)
			^ AFFINE_FWD_CONST;
	endfunction

	function automatic logic [7:0] affine_inv(input logic [7:0] y);
		return rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ AFFINE_INV_CONST;
	endfunction

endpackage

FILE: src/gsb_if.sv
// Valid/ready channel interfaces for the S-box unit request and response.
interface gsb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] operand_a;
	logic [7:0] operand_b;

	modport source (output valid, output mode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input mode, input operand_a, input operand_b,
		output ready);
endinterface

interface gsb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

FILE: src/gsb_prep.sv
// First stage: decode mode and apply the inverse affine map for the inverse S-box.
module gsb_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        mode,
	input  logic [7:0]        operand_a,
	input  logic [7:0]        operand_b,
	output logic              in_ready,
	input  logic              next_en,
	output gsb_pkg::gsb_ctl_t ctl_s1,
	output logic [7:0]        x_s1,
	output logic [7:0]        b_s1
);
	import gsb_pkg::*;

	logic en;
	logic [7:0] x_d;

	// Advance when empty or when the next stage takes our item
	assign en       = !ctl_s1.valid || next_en;
	assign in_ready = en;

	// Pick the byte that goes into the inversion path
	always_comb begin
		if (gsb_mode_t'(mode) == MODE_ISBOX) begin
			x_d = affine_inv(operand_a);
		end else begin
			x_d = operand_a;
		end
	end

	// Control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.mul   <= (gsb_mode_t'(mode) == MODE_MUL);
			ctl_s1.fwd   <= (gsb_mode_t'(mode) == MODE_SBOX);
		end
	end

	// Payload register
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_d;
			b_s1 <= operand_b;
		end
	end
endmodule

FILE: src/gsb_power.sv
// Second stage: form the squares of x and the first level of the product tree.
module gsb_power (
	input  logic              clk,
	input  logic              arst_n,
	input  gsb_pkg::gsb_ctl_t ctl_s1,
	input  logic [7:0]        x_s1,
	input  logic [7:0]        b_s1,
	output logic              en,
	input  logic              next_en,
	output gsb_pkg::gsb_ctl_t ctl_s2,
	output logic [7:0]        p0_s2,
	output logic [7:0]        p1_s2,
	output logic [7:0]        p2_s2,
	output logic [7:0]        p3_s2
);
	import gsb_pkg::*;

	logic [7:0] x2, x4, x8, x16, x32, x64, x128;
	logic [7:0] p0_d, p1_d, p2_d, p3_d;

	assign en = !ctl_s2.valid || next_en;

	// x^254 = x^2 * x^4 * ... * x^128
	always_comb begin
		x2   = gf_sq(x_s1);
		x4   = gf_sq(x2);
		x8   = gf_sq(x4);
		x16  = gf_sq(x8);
		x32  = gf_sq(x16);
		x64  = gf_sq(x32);
		x128 = gf_sq(x64);
	end

	// Multiply mode reuses the tree with ones in the unused leaves
	always_comb begin
		if (ctl_s1.mul) begin
			p0_d = gf_mul(x_s1, b_s1);
			p1_d = GF_ONE;
			p2_d = GF_ONE;
			p3_d = GF_ONE;
		end else begin
			p0_d = gf_mul(x2, x4);
			p1_d = gf_mul(x8, x16);
			p2_d = gf_mul(x32, x64);
			p3_d = x128;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2 <= p0_d;
			p1_s2 <= p1_d;
			p2_s2 <= p2_d;
			p3_s2 <= p3_d;
		end
	end
endmodule

FILE: src/gsb_reduce.sv
// Third and fourth stages: finish the product tree and apply the forward affine map.
module gsb_reduce (
	input  logic              clk,
	input  logic              arst_n,
	input  gsb_pkg::gsb_ctl_t ctl_s2,
	input  logic [7:0]        p0_s2,
	input  logic [7:0]        p1_s2,
	input  logic [7:0]        p2_s2,
	input  logic [7:0]        p3_s2,
	output logic              en_s3,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [7:0]        result
);
	import gsb_pkg::*;

	gsb_ctl_t   ctl_s3;
	logic [7:0] q0_s3, q1_s3;
	logic       valid_s4;
	logic [7:0] result_s4;
	logic       en_s4;
	logic [7:0] prod;

	assign en_s4 = !valid_s4 || out_ready;
	assign en_s3 = !ctl_s3.valid || en_s4;

	// Stage 3: second tree level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en_s3) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			q0_s3 <= gf_mul(p0_s2, p1_s2);
			q1_s3 <= gf_mul(p2_s2, p3_s2);
		end
	end

	// Stage 4: final product, optional affine map, output register
	assign prod = gf_mul(q0_s3, q1_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			result_s4 <= ctl_s3.fwd ? affine_fwd(prod) : prod;
		end
	end

	assign out_valid = valid_s4;
	assign result    = result_s4;
endmodule

FILE: src/gf256_aes_sbox_unit.sv
// Top level of the GF(2^8) multiply / inverse / AES S-box unit.
//
//  channel | dir | payload                       | handshake
//  --------+-----+-------------------------------+-------------
//  req     | in  | mode[1:0], operand_a, operand_b | valid/ready
//  rsp     | out | result[7:0]                   | valid/ready
//
// Four register stages: input decode, squares plus first multiply level,
// second multiply level, final multiply and affine map into the output register.
// One item per cycle sustained while rsp keeps accepting results.
// Each stage holds only while full and blocked downstream, so bubbles collapse
// and a new item is taken while a result waits on rsp.
// Reset clears all stage valid bits; payload registers are not reset.
module gf256_aes_sbox_unit (
	input  logic      clk,
	input  logic      arst_n,
	gsb_req_if.sink   req,
	gsb_rsp_if.source rsp
);
	import gsb_pkg::*;

	gsb_ctl_t   ctl_s1, ctl_s2;
	logic [7:0] x_s1, b_s1;
	logic [7:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic       en_s2, en_s3;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] result;

	gsb_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.mode      (req.mode),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.in_ready  (in_ready),
		.next_en   (en_s2),
		.ctl_s1    (ctl_s1),
		.x_s1      (x_s1),
		.b_s1      (b_s1)
	);

	gsb_power u_power (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.x_s1    (x_s1),
		.b_s1    (b_s1),
		.en      (en_s2),
		.next_en (en_s3),
		.ctl_s2  (ctl_s2),
		.p0_s2   (p0_s2),
		.p1_s2   (p1_s2),
		.p2_s2   (p2_s2),
		.p3_s2   (p3_s2)
	);

	gsb_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s2    (ctl_s2),
		.p0_s2     (p0_s2),
		.p1_s2     (p1_s2),
		.p2_s2     (p2_s2),
		.p3_s2     (p3_s2),
		.en_s3     (en_s3),
		.out_ready (rsp.ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign req.ready  = in_ready;
	assign rsp.valid  = out_valid;
	assign rsp.result = result;
endmodule

FILE: src/gsb_checker.sv
// Port-level checks for the S-box unit, bound to the top level.
module gsb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic [1:0] req_mode,
	input logic [7:0] req_operand_a,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_result
);
	import gsb_pkg::*;

	logic req_xfer;
	assign req_xfer = req_valid && req_ready;

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
		else $error("rsp changed while stalled");

	// Input backpressure only when the output is full and blocked
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("req stalled with output free");

	// A transfer gives a valid response at the output when rsp keeps draining
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
		else $error("result missing after pipeline latency");

	// Zero has inverse zero, so the forward S-box of zero is the affine constant
	a_sbox_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req_mode == MODE_SBOX && req_operand_a == 8'h00
		##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
		|=> rsp_valid && rsp_result == AFFINE_FWD_CONST)
		else $error("sbox of zero is wrong");
endmodule

bind gf256_aes_sbox_unit gsb_checker u_gsb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_mode      (req.mode),
	.req_operand_a (req.operand_a),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_result    (rsp.result)
);

FILE: tb/gf256_aes_sbox_unit_tb.sv
// Self-checking testbench for the GF(2^8) multiply / inverse / AES S-box unit.
module gf256_aes_sbox_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gsb_pkg::*;

	// One operation in flight: what was sent and the byte it must produce
	typedef struct {
		gsb_mode_t  mode;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] result;
	} sbox_op_t;

	logic clk;
	logic arst_n;

	gsb_req_if req_ch ();
	gsb_rsp_if rsp_ch ();

	gf256_aes_sbox_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sbox_op_t    pending_ops[$];
	sbox_op_t    oldest_op;
	int unsigned mismatch_count = 0;
	int unsigned src_idle_pct = 11;
	int unsigned sink_idle_pct = 80;

	// Free-running clock, 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Field arithmetic, AES polynomial
	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
	endfunction

	function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] prod;
		logic [7:0] term;
		prod = 8'h00;
		term = x;
		for (int i = 0; i < 8; i++) begin
			if (y[i]) begin
				prod = prod ^ term;
			end
			term = xtime(term);
		end
		return prod;
	endfunction

	// x^254 by square-and-multiply; zero stays zero
	function automatic logic [7:0] gf_recip(input logic [7:0] x);
		logic [7:0] acc;
		logic [7:0] expo;
		acc = 8'h01;
		expo = 8'd254;
		for (int i = 7; i >= 0; i--) begin
			acc = gf_times(acc, acc);
			if (expo[i]) begin
				acc = gf_times(acc, x);
			end
		end
		return acc;
	endfunction

	// Forward affine map, bit by bit
	function automatic logic [7:0] affine_to_sbox(input logic [7:0] x);
		logic [7:0] y;
		for (int i = 0; i < 8; i++) begin
			y[i] = x[i] ^ x[(i + 4) % 8] ^ x[(i + 5) % 8] ^ x[(i + 6) % 8]
				^ x[(i + 7) % 8] ^ AFFINE_FWD_CONST[i];
		end
		return y;
	endfunction

	// Inverse affine map, bit by bit
	function automatic logic [7:0] affine_from_sbox(input logic [7:0] y);
		logic [7:0] x;
		for (int i = 0; i < 8; i++) begin
			x[i] = y[(i + 2) % 8] ^ y[(i + 5) % 8] ^ y[(i + 7) % 8] ^ AFFINE_INV_CONST[i];
		end
		return x;
	endfunction

	function automatic logic [7:0] predict_byte(input gsb_mode_t m, input logic [7:0] a,
		input logic [7:0] b);
		case (m)
			MODE_MUL: begin
				return gf_times(a, b);
			end
			MODE_INV: begin
				return gf_recip(a);
			end
			MODE_SBOX: begin
				return affine_to_sbox(gf_recip(a));
			end
			default: begin
				return gf_recip(affine_from_sbox(a));
			end
		endcase
	endfunction

	// Bias operands toward the edges of the field
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hff;
			end
			2: begin
				return 8'h01;
			end
			default: begin
				return 8'($urandom_range(255));
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offer one request, hold it until the transfer, record the expected byte
	task automatic send_op(input gsb_mode_t m, input logic [7:0] a, input logic [7:0] b);
		sbox_op_t op;
		logic     took;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= m;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		op.mode   = m;
		op.a      = a;
		op.b      = b;
		op.result = predict_byte(m, a, b);
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = req_ch.ready;
			if (took) begin
				pending_ops.push_back(op);
			end
			@(posedge clk);
		end
	endtask

	// Randomly stall the response side
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Compare each response transfer with the oldest expected byte
	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_ops.size() == 0) begin
				report_mismatch($sformatf("unexpected result %02h", rsp_ch.result));
			end else begin
				oldest_op = pending_ops.pop_front();
				if (rsp_ch.result !== oldest_op.result) begin
					report_mismatch($sformatf("%s a=%02h b=%02h result %02h, want %02h",
						oldest_op.mode.name(), oldest_op.a, oldest_op.b,
						rsp_ch.result, oldest_op.result));
				end
			end
		end
	end

	task automatic test_multiply_corners();
		send_op(MODE_MUL, 8'h00, 8'h00);
		send_op(MODE_MUL, 8'hff, 8'hff);
		send_op(MODE_MUL, 8'h01, 8'ha5);
		send_op(MODE_MUL, 8'h5a, 8'h01);
		send_op(MODE_MUL, 8'h57, 8'h83);
		send_op(MODE_MUL, 8'h80, 8'h02);
		send_op(MODE_MUL, 8'h00, 8'hff);
	endtask

	// Zero inverse and an ignored operand_b
	task automatic test_inverse_corners();
		send_op(MODE_INV, 8'h00, 8'hff);
		send_op(MODE_INV, 8'h01, 8'h5a);
		send_op(MODE_INV, 8'hff, 8'h00);
		send_op(MODE_INV, 8'h53, 8'($urandom_range(255)));
	endtask

	// Both directions of the substitution, including the zero-inverse points
	task automatic test_sbox_corners();
		send_op(MODE_SBOX, 8'h00, 8'hff);
		send_op(MODE_SBOX, 8'hff, 8'h00);
		send_op(MODE_SBOX, 8'h53, 8'($urandom_range(255)));
		send_op(MODE_SBOX, 8'h01, 8'h80);
		send_op(MODE_ISBOX, 8'h63, 8'hff);
		send_op(MODE_ISBOX, 8'h00, 8'h00);
		send_op(MODE_ISBOX, 8'hff, 8'h7e);
		send_op(MODE_ISBOX, 8'hed, 8'($urandom_range(255)));
	endtask

	// Mixed random traffic over three idle profiles
	task automatic test_random_traffic(input int unsigned per_phase);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 11;
					sink_idle_pct = 80;
				end
				1: begin
					src_idle_pct  = 80;
					sink_idle_pct = 11;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			repeat (per_phase) begin
				send_op(gsb_mode_t'($urandom_range(3)), pick_byte(), pick_byte());
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = MODE_MUL;
		req_ch.operand_a = 8'h00;
		req_ch.operand_b = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_multiply_corners();
		test_inverse_corners();
		test_sbox_corners();
		test_random_traffic(534);

		// Drain the pipeline
		req_ch.valid <= 1'b0;
		while (pending_ops.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
src/gsb_pkg.sv
src/gsb_if.sv
src/gsb_prep.sv
src/gsb_power.sv
src/gsb_reduce.sv
src/gf256_aes_sbox_unit.sv
src/gsb_checker.sv
tb/gf256_aes_sbox_unit_tb.sv
